/* rtl/fjd_pkg.sv */
// Package with word types, register indexes and constants of the feeder jam detect core.
`timescale 1ns / 1ps
`default_nettype none

package fjd_pkg;

	// Field widths.
	localparam int SpeedW    = 14;
	localparam int CountW    = 16;
	localparam int RpmW      = 16;
	localparam int TargetW   = 15;
	localparam int DelayW    = 10;
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 16;

	// Saturation and firing thresholds, counted in ticks.
	localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};
	localparam logic [DelayW-1:0] DelayMax  = DelayW'(1000);
	localparam logic [DelayW-1:0] DelayFire = DelayW'(20);

	// Configuration register indexes.
	typedef enum logic [CfgIndexW-1:0] {
		CFG_FEEDER_SPEED     = 3'd0,
		CFG_FLYWHEEL_SPEED   = 3'd1,
		CFG_JAM_SPEED_LIMIT  = 3'd2,
		CFG_STALL_TICK_LIMIT = 3'd3,
		CFG_CLEAR_TICK_LIMIT = 3'd4
	} cfg_index_t;

	// Input word: one control tick.
	typedef struct packed {
		logic                   has_command;
		logic                   mode_continuous;
		logic signed [RpmW-1:0] feeder_rpm;
		logic                   feeder_drive_active;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic signed [TargetW-1:0] feeder_target;
		logic [SpeedW-1:0]         flywheel_target;
		logic                      in_antijam;
	} out_word_t;

	// Current configuration as seen by the control logic.
	typedef struct packed {
		logic [SpeedW-1:0] feeder_speed;
		logic [SpeedW-1:0] flywheel_speed;
		logic [SpeedW-1:0] jam_speed_limit;
		logic [CountW-1:0] stall_tick_limit;
		logic [CountW-1:0] clear_tick_limit;
	} cfg_t;

	// Saturating increment of a tick count.
	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
		return (v == CountMax) ? CountMax : v + CountW'(1);
	endfunction

endpackage

`default_nettype wire

/* rtl/feeder_jam_detect_and_mode_control_core.sv */
// Top level of the feeder jam detect and fire mode control core.
// An accepted input word is held in the input register; the tick logic's result
// is loaded into the output register together with the state update. Throughput:
// one word per cycle while the output is not stalled.
// Reset: arst_n clears all configuration registers, the mode and jam state and the
// counts and targets at once; the block takes words in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module feeder_jam_detect_and_mode_control_core
	import fjd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_word_t             in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_word_t                 out_word,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	cfg_t      cfg;
	in_word_t  word_s1;
	logic      valid_s1;
	out_word_t result;
	out_word_t out_word_q;
	logic      out_valid_q;
	logic      advance;

	// The word in the input stage moves on when the output register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	fjd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fjd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_word;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

/* rtl/fjd_cfg_regs.sv */
// Configuration register file of the feeder jam detect core.
`timescale 1ns / 1ps
`default_nettype none

module fjd_cfg_regs
	import fjd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Write one register per enabled cycle; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_FEEDER_SPEED:     cfg_q.feeder_speed     <= cfg_data[SpeedW-1:0];
				CFG_FLYWHEEL_SPEED:   cfg_q.flywheel_speed   <= cfg_data[SpeedW-1:0];
				CFG_JAM_SPEED_LIMIT:  cfg_q.jam_speed_limit  <= cfg_data[SpeedW-1:0];
				CFG_STALL_TICK_LIMIT: cfg_q.stall_tick_limit <= cfg_data[CountW-1:0];
				CFG_CLEAR_TICK_LIMIT: cfg_q.clear_tick_limit <= cfg_data[CountW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/fjd_ctrl.sv */
// Jam detection and fire mode state with the target computation for one tick.
`timescale 1ns / 1ps
`default_nettype none

module fjd_ctrl
	import fjd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_word_t word,
	input  wire cfg_t     cfg,
	output out_word_t     result
);

	logic                      fire_mode_q;
	logic                      jam_state_q;
	logic                      reverse_dir_q;
	logic [CountW-1:0]         stall_ticks_q;
	logic [CountW-1:0]         clear_ticks_q;
	logic [DelayW-1:0]         start_delay_q;
	logic signed [TargetW-1:0] feeder_tgt_q;
	logic [SpeedW-1:0]         flywheel_tgt_q;

	logic                      fire_mode_d;
	logic                      jam_state_d;
	logic                      reverse_dir_d;
	logic [CountW-1:0]         stall_ticks_d;
	logic [CountW-1:0]         clear_ticks_d;
	logic [DelayW-1:0]         start_delay_d;
	logic signed [TargetW-1:0] feeder_tgt_d;
	logic [SpeedW-1:0]         flywheel_tgt_d;
	logic [RpmW-1:0]           rpm_mag;
	logic                      stalled;
	logic signed [TargetW-1:0] speed_pos;

	// Next state for one tick: command, stall detection, then targets.
	always_comb begin
		fire_mode_d    = word.has_command ? word.mode_continuous : fire_mode_q;
		rpm_mag        = word.feeder_rpm[RpmW-1] ? (~word.feeder_rpm + RpmW'(1))
		                                         : word.feeder_rpm;
		stalled        = word.feeder_drive_active
		                 && (rpm_mag < {{(RpmW-SpeedW){1'b0}}, cfg.jam_speed_limit});
		speed_pos      = {1'b0, cfg.feeder_speed};
		jam_state_d    = jam_state_q;
		reverse_dir_d  = reverse_dir_q;
		start_delay_d  = start_delay_q;
		feeder_tgt_d   = feeder_tgt_q;
		flywheel_tgt_d = flywheel_tgt_q;

		// Count stall ticks, or clear them and count clear ticks.
		if (stalled) begin
			stall_ticks_d = sat_inc(stall_ticks_q);
			clear_ticks_d = clear_ticks_q;
		end else begin
			stall_ticks_d = '0;
			clear_ticks_d = sat_inc(clear_ticks_q);
		end

		// A long stall enters anti-jam and flips direction on every such tick.
		if (stall_ticks_d > cfg.stall_tick_limit) begin
			jam_state_d   = 1'b1;
			reverse_dir_d = ~reverse_dir_q;
			clear_ticks_d = '0;
		end
		if (clear_ticks_d > cfg.clear_tick_limit) begin
			jam_state_d = 1'b0;
		end

		// Targets from the fire mode.
		if (!fire_mode_d) begin
			jam_state_d    = 1'b0;
			reverse_dir_d  = 1'b1;
			feeder_tgt_d   = '0;
			flywheel_tgt_d = '0;
			start_delay_d  = '0;
		end else begin
			if (start_delay_q < DelayMax) begin
				start_delay_d = start_delay_q + DelayW'(1);
			end
			if (!jam_state_d) begin
				if (start_delay_d >= DelayFire) begin
					feeder_tgt_d   = speed_pos;
					flywheel_tgt_d = cfg.flywheel_speed;
				end
			end else begin
				feeder_tgt_d = reverse_dir_d ? -speed_pos : speed_pos;
			end
		end
	end

	// State registers advance once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fire_mode_q    <= 1'b0;
			jam_state_q    <= 1'b0;
			reverse_dir_q  <= 1'b0;
			stall_ticks_q  <= '0;
			clear_ticks_q  <= '0;
			start_delay_q  <= '0;
			feeder_tgt_q   <= '0;
			flywheel_tgt_q <= '0;
		end else if (step) begin
			fire_mode_q    <= fire_mode_d;
			jam_state_q    <= jam_state_d;
			reverse_dir_q  <= reverse_dir_d;
			stall_ticks_q  <= stall_ticks_d;
			clear_ticks_q  <= clear_ticks_d;
			start_delay_q  <= start_delay_d;
			feeder_tgt_q   <= feeder_tgt_d;
			flywheel_tgt_q <= flywheel_tgt_d;
		end
	end

	// Result of the tick in flight, for the output register.
	assign result.feeder_target   = feeder_tgt_d;
	assign result.flywheel_target = flywheel_tgt_d;
	assign result.in_antijam      = jam_state_d;

endmodule

`default_nettype wire

/* dv/feeder_jam_detect_and_mode_control_core_test.sv */
// Self-checking testbench for the feeder jam detect and fire mode control core.
`timescale 1ns / 1ps

module feeder_jam_detect_and_mode_control_core_test;
	import fjd_pkg::*;

	localparam int  CycleLimit     = 300000;
	localparam int  FireDelayMax   = 1000;
	localparam int  FireDelayArm   = 20;
	localparam int  TailCycles     = 10;
	localparam int  ReportLimit    = 10;
	localparam bit  MODE_CEASE     = 1'b0;
	localparam bit  MODE_CONTINUOUS = 1'b1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_word_t             in_word = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_word_t            out_word;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	feeder_jam_detect_and_mode_control_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Ticks waiting to be sent and targets waiting to be seen.
	in_word_t  tick_queue[$];
	out_word_t expected_targets[$];

	int  mismatch_count = 0;
	int  ticks_sent = 0;
	int  results_checked = 0;
	int  cycle_count = 0;
	int  setting_count = 0;
	int  send_gap_left = 0;
	int  hold_left = 0;
	bit  send_gaps_on = 1'b0;
	bit  hold_gaps_on = 1'b0;

	// Predictor copy of the configuration and of the control state.
	cfg_t                      cur_cfg = '0;
	bit                        fire_on = MODE_CEASE;
	bit                        antijam = 1'b0;
	bit                        reversed = 1'b0;
	logic [CountW-1:0]         stall_cnt = '0;
	logic [CountW-1:0]         clear_cnt = '0;
	int                        fire_delay = 0;
	logic signed [TargetW-1:0] feeder_hold = '0;
	logic [SpeedW-1:0]         flywheel_hold = '0;

	function automatic logic [CountW-1:0] bump_count(input logic [CountW-1:0] c);
		return (c == {CountW{1'b1}}) ? c : c + CountW'(1);
	endfunction

	// Advance the predicted state by one tick and return the targets it yields.
	function automatic out_word_t next_targets(input in_word_t w);
		int        rpm;
		int        mag;
		out_word_t r;
		rpm = int'($signed(w.feeder_rpm));
		mag = (rpm < 0) ? -rpm : rpm;
		if (w.has_command) begin
			fire_on = w.mode_continuous;
		end
		// Stall detection and the anti-jam state.
		if (w.feeder_drive_active && mag < int'(cur_cfg.jam_speed_limit)) begin
			stall_cnt = bump_count(stall_cnt);
		end else begin
			stall_cnt = '0;
			clear_cnt = bump_count(clear_cnt);
		end
		if (stall_cnt > cur_cfg.stall_tick_limit) begin
			antijam = 1'b1;
			reversed = ~reversed;
			clear_cnt = '0;
		end
		if (clear_cnt > cur_cfg.clear_tick_limit) begin
			antijam = 1'b0;
		end
		// Targets from the fire mode.
		if (fire_on == MODE_CEASE) begin
			antijam = 1'b0;
			reversed = 1'b1;
			feeder_hold = '0;
			flywheel_hold = '0;
			fire_delay = 0;
		end else begin
			if (fire_delay < FireDelayMax) begin
				fire_delay++;
			end
			if (!antijam) begin
				if (fire_delay >= FireDelayArm) begin
					feeder_hold = $signed({1'b0, cur_cfg.feeder_speed});
					flywheel_hold = cur_cfg.flywheel_speed;
				end
			end else if (reversed) begin
				feeder_hold = -$signed({1'b0, cur_cfg.feeder_speed});
			end else begin
				feeder_hold = $signed({1'b0, cur_cfg.feeder_speed});
			end
		end
		r.feeder_target = feeder_hold;
		r.flywheel_target = flywheel_hold;
		r.in_antijam = antijam;
		return r;
	endfunction

	function automatic in_word_t make_tick(input bit cmd, input bit mode, input int rpm,
			input bit drive);
		in_word_t w;
		w.has_command = cmd;
		w.mode_continuous = mode;
		w.feeder_rpm = RpmW'(rpm);
		w.feeder_drive_active = drive;
		return w;
	endfunction

	function automatic int random_rpm();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Mostly no gap, sometimes a short one, rarely a long one.
	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Word driver: predicts on each accepted tick, then offers the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_targets.push_back(next_targets(in_word));
				ticks_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap_left != 0) begin
					in_valid <= 1'b0;
					send_gap_left <= send_gap_left - 1;
				end else if (tick_queue.size() != 0) begin
					in_valid <= 1'b1;
					in_word <= tick_queue.pop_front();
					send_gap_left <= pick_gap(send_gaps_on);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back pressure.
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_targets.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= ReportLimit) begin
						$display("Unexpected result word: feeder %0d flywheel %0d antijam %0b",
							out_word.feeder_target, out_word.flywheel_target,
							out_word.in_antijam);
					end
				end else begin
					want = expected_targets.pop_front();
					results_checked++;
					if (out_word.feeder_target !== want.feeder_target
							|| out_word.flywheel_target !== want.flywheel_target
							|| out_word.in_antijam !== want.in_antijam) begin
						mismatch_count++;
						if (mismatch_count <= ReportLimit) begin
							$display("Result %0d: expected feeder %0d flywheel %0d antijam %0b, got feeder %0d flywheel %0d antijam %0b",
								results_checked, want.feeder_target,
								want.flywheel_target, want.in_antijam,
								out_word.feeder_target, out_word.flywheel_target,
								out_word.in_antijam);
						end
					end
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else begin
				out_stall <= 1'b0;
				hold_left <= pick_gap(hold_gaps_on);
			end
		end
	end

	// One register write; the predictor follows at the same edge.
	task automatic write_reg(input cfg_index_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CfgDataW'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_FEEDER_SPEED:     cur_cfg.feeder_speed = SpeedW'(value);
			CFG_FLYWHEEL_SPEED:   cur_cfg.flywheel_speed = SpeedW'(value);
			CFG_JAM_SPEED_LIMIT:  cur_cfg.jam_speed_limit = SpeedW'(value);
			CFG_STALL_TICK_LIMIT: cur_cfg.stall_tick_limit = CountW'(value);
			CFG_CLEAR_TICK_LIMIT: cur_cfg.clear_tick_limit = CountW'(value);
			default: ;
		endcase
	endtask

	task automatic write_setting(input int feeder, input int flywheel, input int jam,
			input int stall_lim, input int clear_lim);
		write_reg(CFG_FEEDER_SPEED, feeder);
		write_reg(CFG_FLYWHEEL_SPEED, flywheel);
		write_reg(CFG_JAM_SPEED_LIMIT, jam);
		write_reg(CFG_STALL_TICK_LIMIT, stall_lim);
		write_reg(CFG_CLEAR_TICK_LIMIT, clear_lim);
		setting_count++;
	endtask

	// Let the queue empty and every expected word come back.
	task automatic drain();
		while (tick_queue.size() != 0 || in_valid || expected_targets.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Random ticks shaped as stall runs and clear runs around the current limits.
	task automatic queue_ticks(input int n);
		int queued;
		int len;
		int mag;
		int jam;
		int run_s;
		int run_c;
		bit drive;
		queued = 0;
		jam = int'(cur_cfg.jam_speed_limit);
		run_s = (cur_cfg.stall_tick_limit > 12) ? 12 : int'(cur_cfg.stall_tick_limit) + 3;
		run_c = (cur_cfg.clear_tick_limit > 12) ? 12 : int'(cur_cfg.clear_tick_limit) + 3;
		tick_queue.push_back(make_tick(1'b1, MODE_CONTINUOUS, random_rpm(), 1'b0));
		while (queued < n) begin
			case ($urandom_range(0, 9))
				0: begin
					tick_queue.push_back(make_tick($urandom_range(0, 3) == 0,
						1'($urandom_range(0, 1)), random_rpm(),
						1'($urandom_range(0, 1))));
					queued++;
				end
				1: begin
					tick_queue.push_back(make_tick(1'b1, $urandom_range(0, 7) != 0,
						random_rpm(), 1'($urandom_range(0, 1))));
					queued++;
				end
				2, 3, 4, 5: begin
					len = $urandom_range(1, run_s);
					repeat (len) begin
						mag = (jam == 0) ? $urandom_range(0, 32767) : $urandom_range(0, jam - 1);
						tick_queue.push_back(make_tick($urandom_range(0, 15) == 0,
							MODE_CONTINUOUS, $urandom_range(0, 1) ? -mag : mag, 1'b1));
					end
					queued += len;
				end
				6, 7, 8: begin
					len = $urandom_range(1, run_c);
					repeat (len) begin
						drive = 1'($urandom_range(0, 1));
						mag = drive ? $urandom_range(jam, 32767) : $urandom_range(0, 32767);
						tick_queue.push_back(make_tick(1'b0, 1'($urandom_range(0, 1)),
							$urandom_range(0, 1) ? -mag : mag, drive));
					end
					queued += len;
				end
				default: begin
					// Cease, then start firing again from a zero start delay.
					tick_queue.push_back(make_tick(1'b1, MODE_CEASE, random_rpm(), 1'b1));
					tick_queue.push_back(make_tick(1'b1, MODE_CONTINUOUS, random_rpm(), 1'b0));
					queued += 2;
				end
			endcase
		end
	endtask

	// Main sequence: directed ticks, then random ticks under several settings.
	initial begin
		int edge_rpm[4];
		edge_rpm = '{32767, -32768, 16383, -16383};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Full-scale speeds with short limits so that every path shows up quickly.
		write_setting(16383, 16383, 16383, 2, 1);
		tick_queue.push_back(make_tick(1'b1, MODE_CONTINUOUS, 0, 1'b0));
		// Start delay runs up with speeds at the edges of the stall threshold; the mode
		// bit without a command must be ignored.
		for (int i = 0; i < 19; i++) begin
			tick_queue.push_back(make_tick(1'b0, i[1], edge_rpm[i % 4], i[0]));
		end
		// A stall run long enough to enter anti-jam and flip direction each tick.
		tick_queue.push_back(make_tick(1'b0, MODE_CONTINUOUS, 16382, 1'b1));
		tick_queue.push_back(make_tick(1'b0, MODE_CONTINUOUS, -16382, 1'b1));
		tick_queue.push_back(make_tick(1'b0, MODE_CONTINUOUS, 0, 1'b1));
		tick_queue.push_back(make_tick(1'b0, MODE_CONTINUOUS, -1, 1'b1));
		// Clear ticks past the clear limit return to normal, then cease.
		tick_queue.push_back(make_tick(1'b0, MODE_CONTINUOUS, 0, 1'b0));
		tick_queue.push_back(make_tick(1'b0, MODE_CONTINUOUS, -32768, 1'b1));
		tick_queue.push_back(make_tick(1'b1, MODE_CEASE, 5, 1'b1));
		drain();

		// Zero everywhere: no tick can ever count as stalled.
		send_gaps_on = 1'b1;
		hold_gaps_on = 1'b0;
		write_setting(0, 0, 0, 0, 0);
		queue_ticks(60);
		drain();

		// Largest values: the tick limits are never exceeded.
		send_gaps_on = 1'b0;
		hold_gaps_on = 1'b1;
		write_setting(16383, 16383, 16383, 65535, 65535);
		queue_ticks(60);
		drain();

		// Random speeds with small tick limits; idling varies per setting.
		for (int p = 0; p < 6; p++) begin
			send_gaps_on = (p % 3) != 2;
			hold_gaps_on = (p % 3) != 1;
			write_setting($urandom_range(0, 16383), $urandom_range(0, 16383),
				$urandom_range(1, 16383), $urandom_range(0, 6), $urandom_range(0, 6));
			queue_ticks(55);
			drain();
		end

		repeat (TailCycles) @(posedge clk);
		$display("Sent %0d ticks under %0d register settings and checked %0d results.",
			ticks_sent, setting_count, results_checked);
		$display("Covered stall and clear runs, anti-jam entry and exit, cease and restart.");
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/fjd_pkg.sv
rtl/fjd_cfg_regs.sv
rtl/fjd_ctrl.sv
rtl/feeder_jam_detect_and_mode_control_core.sv
dv/feeder_jam_detect_and_mode_control_core_test.sv
